// ===== design/srsw_pkg.sv =====
// Package: item types, command and outcome codes for the selective-repeat sender window.
`timescale 1ns / 1ps

package srsw_pkg;

  // Internal sequence counters follow the width of the seq_count register.
  localparam int unsigned SEQ_W = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEQ_COUNT   = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [4:0] SEQ_COUNT_RST   = 5'd8;
  localparam logic [3:0] WINDOW_SIZE_RST = 4'd4;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } srsw_cmd_e;

  typedef enum logic [2:0] {
    OUT_SENT        = 3'd0,
    OUT_REFUSED     = 3'd1,
    OUT_ACK_IN      = 3'd2,
    OUT_ACK_OUTSIDE = 3'd3,
    OUT_ACK_CORRUPT = 3'd4,
    OUT_RESENT      = 3'd5
  } srsw_outcome_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] payload;
    logic [3:0]  seq_number;
    logic        ack_intact;
  } srsw_in_t;

  typedef struct packed {
    srsw_outcome_e outcome;
    logic          packet_valid;
    logic [3:0]    packet_seq;
    logic [63:0]   packet_payload;
    logic          timer_stop;
    logic          timer_start;
    logic [3:0]    timer_seq;
    logic [3:0]    window_base;
    logic [3:0]    next_to_send;
    logic          window_full;
  } srsw_out_t;

endpackage

// ===== design/selective_repeat_sender_window_core.sv =====
// Top level: selective-repeat ARQ sender window with its payload store and ack marks.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// command   in         start high while busy low    item_i (srsw_in_t)
// result    out        result_valid_o, one cycle    result_o (srsw_out_t)
// config    in         cfg_valid_i and cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item is accepted on the edge where start is high and busy is low. Sends, timeouts,
// refused sends and acks that mark nothing pass through the execute state and then show
// their result in the done state; an ack inside the window passes through the walk state
// between them, where the base walks one mark per cycle. A new item may be accepted in the
// cycle its predecessor's result is shown. An item with the unused command code is accepted
// and dropped without a result. Reset is asynchronous and restores the register defaults
// and an empty window; the payload store is not cleared. The receiver cannot stall, so a
// result is valid for exactly one cycle.

module selective_repeat_sender_window_core #(
  parameter int unsigned SEQ_MAX      = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  srsw_pkg::srsw_in_t item_i,
  output logic               result_valid_o,
  output srsw_pkg::srsw_out_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [4:0]         cfg_data_i
);
  import srsw_pkg::*;

  // The count register is five bits wide, so no more than 31 numbers are ever in use.
  localparam int unsigned DEPTH = (SEQ_MAX < 31) ? SEQ_MAX : 31;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam logic [SEQ_W-1:0] CntMax = SEQ_W'(DEPTH);
  localparam logic [SEQ_W-1:0] CntMin = SEQ_W'(2);

  // One-hot sequencer.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [4:0] seq_count_q;
  logic [3:0] window_size_q;

  // Window state. Marks are flip-flops so reset and a register write clear them at once.
  logic [SEQ_W-1:0] base_q, next_q;
  logic [DEPTH-1:0] marks_q;

  // Item register.
  logic [1:0]              cmd_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [3:0]              seq_q;
  logic                    intact_q;

  // Result fields other than the status, which is taken from the window registers.
  srsw_outcome_e           outcome_q;
  logic                    pv_q, tstop_q, tstart_q;
  logic [3:0]              pseq_q, tseq_q;
  logic [PAYLOAD_BITS-1:0] ppay_q;

  // Payload store: one write port and one registered read port.
  logic [PAYLOAD_BITS-1:0] store_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] rdata_q;
  logic                    store_we;
  logic [IW-1:0]           store_raddr;

  logic accept, cmd_known, cfg_we, cfg_restart;
  logic [SEQ_W-1:0] sc_eff, w_eff, top_cur, seq_ext;
  logic full_cur, in_win, mark_at_base;

  // Top of the window: (base + w) mod sc, where both terms are below sc.
  function automatic logic [SEQ_W-1:0] window_top(input logic [SEQ_W-1:0] base,
                                                  input logic [SEQ_W-1:0] w,
                                                  input logic [SEQ_W-1:0] sc);
    logic [SEQ_W:0] sum;
    sum = {1'b0, base} + {1'b0, w};
    if (sum >= {1'b0, sc}) begin
      window_top = SEQ_W'(sum - {1'b0, sc});
    end else begin
      window_top = sum[SEQ_W-1:0];
    end
  endfunction

  function automatic logic [SEQ_W-1:0] wrap_inc(input logic [SEQ_W-1:0] x,
                                                input logic [SEQ_W-1:0] sc);
    logic [SEQ_W-1:0] nx;
    nx = x + SEQ_W'(1);
    wrap_inc = (nx >= sc) ? '0 : nx;
  endfunction

  // Effective count and window after clamping.
  always_comb begin
    if (seq_count_q < CntMin) begin
      sc_eff = CntMin;
    end else if (seq_count_q > CntMax) begin
      sc_eff = CntMax;
    end else begin
      sc_eff = seq_count_q;
    end
    if (window_size_q == 4'd0) begin
      w_eff = SEQ_W'(1);
    end else if ({1'b0, window_size_q} > (sc_eff - SEQ_W'(1))) begin
      w_eff = sc_eff - SEQ_W'(1);
    end else begin
      w_eff = {1'b0, window_size_q};
    end
  end

  assign top_cur  = window_top(base_q, w_eff, sc_eff);
  assign full_cur = (top_cur == next_q);
  assign seq_ext  = {1'b0, seq_q};

  // Membership test for the acked number; numbers at or above the count lie outside.
  always_comb begin
    if (seq_ext >= sc_eff) begin
      in_win = 1'b0;
    end else if (base_q < top_cur) begin
      in_win = (seq_ext >= base_q) && (seq_ext < top_cur);
    end else begin
      in_win = (seq_ext >= base_q) || (seq_ext < top_cur);
    end
  end

  assign mark_at_base = marks_q[base_q[IW-1:0]];

  assign cmd_known = (item_i.cmd == CMD_SEND) || (item_i.cmd == CMD_ACK) ||
                     (item_i.cmd == CMD_TIMEOUT);
  assign busy        = !((state_q == ST_IDLE) || (state_q == ST_DONE));
  assign accept      = start && !busy;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_we && ((cfg_index_i == CFG_SEQ_COUNT) ||
                                  (cfg_index_i == CFG_WINDOW_SIZE));

  // The store is written only in the execute cycle and read only on acceptance, so a read
  // and a write never meet in the same cycle and no forwarding is needed.
  assign store_we    = (state_q == ST_EXEC) && (cmd_q == CMD_SEND) && !full_cur;
  assign store_raddr = IW'({1'b0, item_i.seq_number});

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[next_q[IW-1:0]] <= pay_q;
    end
    if (accept) begin
      rdata_q <= store_mem[store_raddr];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept && cmd_known) begin
          state_d = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if ((cmd_q == CMD_ACK) && intact_q && in_win) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        if (!mark_at_base) begin
          state_d = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state: sequencer, registers and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seq_count_q   <= SEQ_COUNT_RST;
      window_size_q <= WINDOW_SIZE_RST;
      base_q        <= '0;
      next_q        <= '0;
      marks_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_restart) begin
        if (cfg_index_i == CFG_SEQ_COUNT) begin
          seq_count_q <= cfg_data_i;
        end else begin
          window_size_q <= cfg_data_i[3:0];
        end
        base_q  <= '0;
        next_q  <= '0;
        marks_q <= '0;
      end else begin
        case (state_q)
          ST_EXEC: begin
            if (store_we) begin
              marks_q[next_q[IW-1:0]] <= 1'b0;
              next_q <= wrap_inc(next_q, sc_eff);
            end else if ((cmd_q == CMD_ACK) && intact_q && in_win) begin
              marks_q[seq_ext[IW-1:0]] <= 1'b1;
            end
          end
          ST_WALK: begin
            // Retire one marked entry at the base per cycle.
            if (mark_at_base) begin
              marks_q[base_q[IW-1:0]] <= 1'b0;
              base_q <= wrap_inc(base_q, sc_eff);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Item register and result fields: payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= item_i.cmd;
      pay_q    <= item_i.payload[PAYLOAD_BITS-1:0];
      seq_q    <= item_i.seq_number;
      intact_q <= item_i.ack_intact;
    end
    if (state_q == ST_EXEC) begin
      case (cmd_q)
        CMD_SEND: begin
          if (full_cur) begin
            outcome_q <= OUT_REFUSED;
            pv_q      <= 1'b0;
            pseq_q    <= '0;
            ppay_q    <= '0;
            tstop_q   <= 1'b0;
            tstart_q  <= 1'b0;
            tseq_q    <= '0;
          end else begin
            outcome_q <= OUT_SENT;
            pv_q      <= 1'b1;
            pseq_q    <= next_q[3:0];
            ppay_q    <= pay_q;
            tstop_q   <= 1'b0;
            tstart_q  <= 1'b1;
            tseq_q    <= next_q[3:0];
          end
        end
        CMD_ACK: begin
          pv_q     <= 1'b0;
          pseq_q   <= '0;
          ppay_q   <= '0;
          tstart_q <= 1'b0;
          if (!intact_q) begin
            outcome_q <= OUT_ACK_CORRUPT;
            tstop_q   <= 1'b0;
            tseq_q    <= '0;
          end else begin
            outcome_q <= in_win ? OUT_ACK_IN : OUT_ACK_OUTSIDE;
            tstop_q   <= 1'b1;
            tseq_q    <= seq_q;
          end
        end
        default: begin
          // Timeout: resend from the store; a number beyond the store resends zero.
          outcome_q <= OUT_RESENT;
          pv_q      <= 1'b1;
          pseq_q    <= seq_q;
          ppay_q    <= (32'(seq_q) < SEQ_MAX) ? rdata_q : '0;
          tstop_q   <= 1'b1;
          tstart_q  <= 1'b1;
          tseq_q    <= seq_q;
        end
      endcase
    end
  end

  // The result shows the window as it stands after the step.
  assign result_valid_o = (state_q == ST_DONE);

  always_comb begin
    result_o                = '0;
    result_o.outcome        = outcome_q;
    result_o.packet_valid   = pv_q;
    result_o.packet_seq     = pseq_q;
    result_o.packet_payload = 64'(ppay_q);
    result_o.timer_stop     = tstop_q;
    result_o.timer_start    = tstart_q;
    result_o.timer_seq      = tseq_q;
    result_o.window_base    = base_q[3:0];
    result_o.next_to_send   = next_q[3:0];
    result_o.window_full    = full_cur;
  end

endmodule

// ===== design/srsw_checker.sv =====
// Checker: port-level properties of the sender window, bound to the top level.
`timescale 1ns / 1ps

module srsw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input srsw_pkg::srsw_in_t  item_i,
  input logic                result_valid_o,
  input srsw_pkg::srsw_out_t result_o
);
  import srsw_pkg::*;

  // A result is shown for a single cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // An accepted known command keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((item_i.cmd == CMD_SEND) || (item_i.cmd == CMD_ACK) ||
                        (item_i.cmd == CMD_TIMEOUT))) |=> busy)
    else $error("accepted item did not make the block busy");

  // A send issues a packet and a timer start on the same number.
  a_send_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.outcome == OUT_SENT)) |->
      (result_o.packet_valid && result_o.timer_start && !result_o.timer_stop &&
       (result_o.timer_seq == result_o.packet_seq)))
    else $error("send result with inconsistent packet or timer fields");

  // No packet means zero packet fields.
  a_no_packet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.packet_valid) |->
      ((result_o.packet_seq == 4'd0) && (result_o.packet_payload == 64'd0)))
    else $error("packet fields not zero without a packet");

  // A refused send leaves the window full.
  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.outcome == OUT_REFUSED)) |-> result_o.window_full)
    else $error("send refused while the window is not full");

endmodule

bind selective_repeat_sender_window_core srsw_checker u_srsw_checker (.*);

// ===== tb/selective_repeat_sender_window_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the selective-repeat ARQ sender window core.

// The bench drives command items through the start/busy handshake and writes the
// two configuration registers only while the block is idle. A behavioral copy of
// the sender window tracks base, next sequence number, ack marks and the payload
// store. It predicts every result item, and a monitor compares results field by
// field in arrival order. A short table of directed items opens the run. Random
// segments follow, each under its own register setting and idle pattern.
module selective_repeat_sender_window_core_test;
  import srsw_pkg::*;

  localparam int unsigned SEQ_SLOTS       = 16;
  localparam int unsigned CLK_HALF_NS     = 5;
  localparam int unsigned QUIET_CYCLES    = 24;
  localparam int unsigned SEGMENTS        = 10;
  localparam int unsigned SEGMENT_ITEMS   = 133;
  localparam int unsigned DIRECTED_ROWS   = 25;
  localparam int unsigned MAX_REPORTS     = 100;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  // The command code that the package leaves unnamed, and the register indexes
  // that decode to no register at all.
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  // Directed payloads: all ones, all zeros and a mixed pattern.
  localparam logic [63:0] P_ONES = '1;
  localparam logic [63:0] P_ZERO = '0;
  localparam logic [63:0] P_MIX  = 64'hA5A5_5A5A_0FF0_F00F;

  // Register settings of the first random segments: both ends of each range
  // and values that the block has to clamp.
  localparam logic [4:0] COUNT_PLAN  [6] = '{5'd2, 5'd16, 5'd16, 5'd0, 5'd31, 5'd3};
  localparam logic [4:0] WINDOW_PLAN [6] = '{5'd1, 5'd15, 5'd1, 5'd0, 5'd31, 5'd15};

  typedef struct {
    srsw_in_t  item;
    bit        typed;
    srsw_out_t want;
  } drive_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  srsw_in_t   item_i      = '0;
  logic       result_valid_o;
  srsw_out_t  result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_SEQ_COUNT;
  logic [4:0] cfg_data_i  = '0;

  // Behavioral copy of the window. The store keeps a written flag per slot, so
  // that timeouts are only issued for slots that hold a payload.
  logic [4:0]  seq_count_q   = SEQ_COUNT_RST;
  logic [3:0]  window_size_q = WINDOW_SIZE_RST;
  int unsigned base_q        = 0;
  int unsigned next_q        = 0;
  bit          acked_q  [SEQ_SLOTS];
  logic [63:0] store_q  [SEQ_SLOTS];
  bit          stored_q [SEQ_SLOTS];

  srsw_out_t   window_reports_q [$];
  int unsigned mismatch_count = 0;

  drive_row_t  directed_rows [DIRECTED_ROWS];

  selective_repeat_sender_window_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------------

  // Sequence count in use: the register value clamped to [2, SEQ_SLOTS].
  function automatic int unsigned live_count();
    int unsigned c;
    c = seq_count_q;
    if (c < 2) c = 2;
    if (c > SEQ_SLOTS) c = SEQ_SLOTS;
    return c;
  endfunction

  // Window size in use: the register value clamped to [1, count - 1].
  function automatic int unsigned live_window(int unsigned sc);
    int unsigned w;
    w = window_size_q;
    if (w < 1) w = 1;
    if (w > sc - 1) w = sc - 1;
    return w;
  endfunction

  function automatic int unsigned bump(int unsigned x, int unsigned sc);
    return (x + 1 >= sc) ? 0 : x + 1;
  endfunction

  function automatic bit window_closed(int unsigned sc, int unsigned w);
    return ((base_q + w) % sc) == (next_q % sc);
  endfunction

  // True when s lies in [base, base + w) modulo the count. Numbers at or above
  // the count never do, even if they would fit by plain comparison.
  function automatic bit covers(int unsigned s, int unsigned sc, int unsigned w);
    int unsigned top;
    top = (base_q + w) % sc;
    if (s >= sc) return 1'b0;
    if (base_q < top) return (s >= base_q) && (s < top);
    return (s >= base_q) || (s < top);
  endfunction

  // Any register write restarts the window. The store survives it. Writes to
  // an index with no register behind it change nothing.
  function automatic void apply_register_write(logic [1:0] idx, logic [4:0] data);
    if (idx == CFG_SEQ_COUNT || idx == CFG_WINDOW_SIZE) begin
      if (idx == CFG_SEQ_COUNT) begin
        seq_count_q = data;
      end else begin
        window_size_q = data[3:0];
      end
      base_q = 0;
      next_q = 0;
      foreach (acked_q[k]) acked_q[k] = 1'b0;
    end
  endfunction

  // Advances the model by one accepted item. Returns 0 when the item causes no
  // result, which only the unused command code does.
  function automatic bit step_sender_window(input srsw_in_t it, output srsw_out_t r);
    int unsigned sc;
    int unsigned w;
    int unsigned s;
    int unsigned n;
    int unsigned k;
    sc = live_count();
    w  = live_window(sc);
    s  = it.seq_number;
    r  = '0;
    case (it.cmd)
      CMD_SEND: begin
        if (window_closed(sc, w)) begin
          r.outcome = OUT_REFUSED;
        end else begin
          n = next_q;
          acked_q[n]  = 1'b0;
          store_q[n]  = it.payload;
          stored_q[n] = 1'b1;
          r.outcome        = OUT_SENT;
          r.packet_valid   = 1'b1;
          r.packet_seq     = 4'(n);
          r.packet_payload = it.payload;
          r.timer_start    = 1'b1;
          r.timer_seq      = 4'(n);
          next_q = bump(n, sc);
        end
      end
      CMD_ACK: begin
        if (!it.ack_intact) begin
          // A corrupt ack commands no timer and leaves the window alone.
          r.outcome = OUT_ACK_CORRUPT;
        end else begin
          r.timer_stop = 1'b1;
          r.timer_seq  = it.seq_number;
          if (covers(s, sc, w)) begin
            r.outcome  = OUT_ACK_IN;
            acked_q[s] = 1'b1;
            // The base walks past every marked entry and clears it.
            for (k = 0; k < sc; k++) begin
              if (!acked_q[base_q]) break;
              acked_q[base_q] = 1'b0;
              base_q = bump(base_q, sc);
            end
          end else begin
            r.outcome = OUT_ACK_OUTSIDE;
          end
        end
      end
      CMD_TIMEOUT: begin
        // A timeout resends from the store whatever the state of the window.
        r.outcome        = OUT_RESENT;
        r.packet_valid   = 1'b1;
        r.packet_seq     = it.seq_number;
        r.packet_payload = store_q[s];
        r.timer_stop     = 1'b1;
        r.timer_start    = 1'b1;
        r.timer_seq      = it.seq_number;
      end
      default: begin
        return 1'b0;
      end
    endcase
    r.window_base  = 4'(base_q);
    r.next_to_send = 4'(next_q);
    r.window_full  = window_closed(sc, w);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic srsw_in_t mk_in(logic [1:0] c, logic [63:0] p, logic [3:0] s,
                                     logic a);
    srsw_in_t it;
    it.cmd        = c;
    it.payload    = p;
    it.seq_number = s;
    it.ack_intact = a;
    return it;
  endfunction

  function automatic srsw_out_t mk_out(srsw_outcome_e oc, logic pv, logic [3:0] pseq,
                                       logic [63:0] ppay, logic tstop, logic tstart,
                                       logic [3:0] tseq, logic [3:0] wb,
                                       logic [3:0] nts, logic full);
    srsw_out_t r;
    r.outcome        = oc;
    r.packet_valid   = pv;
    r.packet_seq     = pseq;
    r.packet_payload = ppay;
    r.timer_stop     = tstop;
    r.timer_start    = tstart;
    r.timer_seq      = tseq;
    r.window_base    = wb;
    r.next_to_send   = nts;
    r.window_full    = full;
    return r;
  endfunction

  // Random items are mostly protocol-shaped: sends, acks of outstanding
  // numbers and timeouts of stored slots. The rest is stray acks, corrupt
  // acks and the unused command. Unused fields carry random bits or an extreme payload.
  function automatic srsw_in_t next_random_item();
    srsw_in_t    it;
    int unsigned sc;
    int unsigned pend;
    int unsigned roll;
    int unsigned pick;
    int unsigned k;
    sc   = live_count();
    pend = (next_q + sc - base_q) % sc;
    it.cmd        = CMD_SEND;
    it.payload    = {$urandom, $urandom};
    it.seq_number = 4'($urandom_range(15));
    it.ack_intact = 1'($urandom_range(1));
    if ($urandom_range(15) == 0) it.payload = $urandom_range(1) ? P_ONES : P_ZERO;
    roll = $urandom_range(99);
    if (roll < 36) begin
      it.cmd = CMD_SEND;
    end else if (roll < 66) begin
      if (pend != 0) begin
        it.cmd        = CMD_ACK;
        it.ack_intact = 1'b1;
        it.seq_number = 4'((base_q + $urandom_range(pend - 1)) % sc);
      end
    end else if (roll < 74) begin
      it.cmd        = CMD_ACK;
      it.ack_intact = 1'b1;
    end else if (roll < 80) begin
      it.cmd        = CMD_ACK;
      it.ack_intact = 1'b0;
    end else if (roll < 95) begin
      // Prefer a number in the window, else any slot that has ever been written.
      // The search starts at the chosen number and only stops on a stored slot,
      // since the base may have walked past numbers that were never sent.
      if (pend != 0 && $urandom_range(1)) begin
        pick = (base_q + $urandom_range(pend - 1)) % sc;
      end else begin
        pick = $urandom_range(SEQ_SLOTS - 1);
      end
      for (k = 0; k < SEQ_SLOTS; k++) begin
        if (stored_q[(pick + k) % SEQ_SLOTS]) begin
          it.cmd        = CMD_TIMEOUT;
          it.seq_number = 4'((pick + k) % SEQ_SLOTS);
          break;
        end
      end
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // Idle pattern of a segment: none, an idle gap before 59 items of a hundred, or before 17.
  function automatic int unsigned pick_gap(int unsigned phase);
    int unsigned chance;
    chance = (phase == 1) ? 59 : (phase == 2) ? 17 : 0;
    if ($urandom_range(99) < chance) return $urandom_range(1, 5);
    return 0;
  endfunction

  // Presents one item and holds it until the block takes it. The model steps
  // on the accepting edge. A typed row pushes its typed result instead of the
  // predicted one, while the model still advances.
  task automatic issue_item(input srsw_in_t it, input int unsigned gap,
                            input bit typed, input srsw_out_t typed_r);
    srsw_out_t exp_r;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (step_sender_window(it, exp_r)) window_reports_q.push_back(typed ? typed_r : exp_r);
  endtask

  // Waits until every expected result has arrived and the block has gone
  // quiet. The extra cycles cover a base walk or a dropped item still in flight.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (window_reports_q.size() != 0 || busy);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [4:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register_write(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Results cannot be held off, so every strobed cycle is one result item.
  // Sampling on the edge reads the values of the cycle that the edge ends.
  always @(posedge clk_i) begin : check_results
    srsw_out_t want;
    if (rst_ni && result_valid_o) begin
      if (window_reports_q.size() == 0) begin
        report_mismatch("unexpected result, outcome", result_o.outcome, '0);
      end else begin
        want = window_reports_q.pop_front();
        check_field("outcome",        result_o.outcome,        want.outcome);
        check_field("packet_valid",   result_o.packet_valid,   want.packet_valid);
        check_field("packet_seq",     result_o.packet_seq,     want.packet_seq);
        check_field("packet_payload", result_o.packet_payload, want.packet_payload);
        check_field("timer_stop",     result_o.timer_stop,     want.timer_stop);
        check_field("timer_start",    result_o.timer_start,    want.timer_start);
        check_field("timer_seq",      result_o.timer_seq,      want.timer_seq);
        check_field("window_base",    result_o.window_base,    want.window_base);
        check_field("next_to_send",   result_o.next_to_send,   want.next_to_send);
        check_field("window_full",    result_o.window_full,    want.window_full);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_test
    int unsigned seg;
    int unsigned i;
    int unsigned phase;
    logic [4:0]  count_val;
    logic [4:0]  window_val;

    // The directed part runs under the reset setting: count 8, window 4.
    // Rows with typed results can be read off directly. The rest follow the model.
    directed_rows = '{
      // Fill the window from empty, with extreme payloads.
      '{mk_in(CMD_SEND, P_ONES, 4'hF, 1'b1), 1'b1,
        mk_out(OUT_SENT, 1'b1, 4'd0, P_ONES, 1'b0, 1'b1, 4'd0, 4'd0, 4'd1, 1'b0)},
      '{mk_in(CMD_SEND, P_ZERO, 4'h0, 1'b0), 1'b1,
        mk_out(OUT_SENT, 1'b1, 4'd1, P_ZERO, 1'b0, 1'b1, 4'd1, 4'd0, 4'd2, 1'b0)},
      '{mk_in(CMD_SEND, P_MIX, 4'h5, 1'b0), 1'b1,
        mk_out(OUT_SENT, 1'b1, 4'd2, P_MIX, 1'b0, 1'b1, 4'd2, 4'd0, 4'd3, 1'b0)},
      '{mk_in(CMD_SEND, 64'd1, 4'hA, 1'b1), 1'b1,
        mk_out(OUT_SENT, 1'b1, 4'd3, 64'd1, 1'b0, 1'b1, 4'd3, 4'd0, 4'd4, 1'b1)},
      // A send into a full window is refused.
      '{mk_in(CMD_SEND, P_ONES, 4'hF, 1'b1), 1'b1,
        mk_out(OUT_REFUSED, 1'b0, 4'd0, P_ZERO, 1'b0, 1'b0, 4'd0, 4'd0, 4'd4, 1'b1)},
      // Corrupt ack, then an ack numbered beyond the sequence count.
      '{mk_in(CMD_ACK, P_ZERO, 4'h0, 1'b0), 1'b1,
        mk_out(OUT_ACK_CORRUPT, 1'b0, 4'd0, P_ZERO, 1'b0, 1'b0, 4'd0, 4'd0, 4'd4, 1'b1)},
      '{mk_in(CMD_ACK, P_ONES, 4'hF, 1'b1), 1'b1,
        mk_out(OUT_ACK_OUTSIDE, 1'b0, 4'd0, P_ZERO, 1'b1, 1'b0, 4'd15, 4'd0, 4'd4, 1'b1)},
      // Ack outside the window, then out-of-order acks that move the base.
      '{mk_in(CMD_ACK, P_ZERO, 4'h5, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h1, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h0, 1'b1), 1'b0, '0},
      // A timeout of an already acknowledged number still resends.
      '{mk_in(CMD_TIMEOUT, P_ZERO, 4'h0, 1'b0), 1'b1,
        mk_out(OUT_RESENT, 1'b1, 4'd0, P_ONES, 1'b1, 1'b1, 4'd0, 4'd2, 4'd4, 1'b0)},
      '{mk_in(CMD_TIMEOUT, P_ONES, 4'h2, 1'b1), 1'b0, '0},
      // The unused command is dropped without a result.
      '{mk_in(CMD_UNUSED, P_ONES, 4'hF, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h1, 1'b1), 1'b0, '0},
      '{mk_in(CMD_SEND, 64'h8000_0000_0000_0001, 4'h3, 1'b1), 1'b0, '0},
      '{mk_in(CMD_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 4'hC, 1'b0), 1'b0, '0},
      '{mk_in(CMD_SEND, P_MIX, 4'h0, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h3, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h2, 1'b1), 1'b0, '0},
      // Sending across the wrap of the sequence numbers.
      '{mk_in(CMD_SEND, 64'h0123_4567_89AB_CDEF, 4'h9, 1'b0), 1'b0, '0},
      '{mk_in(CMD_SEND, 64'hFEDC_BA98_7654_3210, 4'h6, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h7, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h5, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h4, 1'b1), 1'b0, '0},
      '{mk_in(CMD_ACK, P_ZERO, 4'h6, 1'b1), 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      issue_item(directed_rows[r].item, 0, directed_rows[r].typed, directed_rows[r].want);
    end

    // Each random segment restarts the window with a new register setting.
    // The first segments use the extremes and values that need clamping.
    // Later segments draw the setting at random, the count mostly within its legal range.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 6) begin
        count_val  = COUNT_PLAN[seg];
        window_val = WINDOW_PLAN[seg];
      end else begin
        count_val  = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                              : 5'($urandom_range(2, 16));
        window_val = 5'($urandom_range(31));
      end
      write_register(CFG_SEQ_COUNT, count_val);
      write_register(CFG_WINDOW_SIZE, window_val);
      phase = seg % 3;
      for (i = 0; i < SEGMENT_ITEMS; i++) begin
        // Halfway through some segments, a write to an index with no register
        // behind it must leave the window as it stands.
        if (i == SEGMENT_ITEMS / 2 && seg % 4 == 1) begin
          write_register((seg % 8 == 1) ? CFG_SPARE_2 : CFG_SPARE_3, 5'($urandom_range(31)));
        end
        issue_item(next_random_item(), pick_gap(phase), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** selective_repeat_sender_window_core: PASSED **");
    end else begin
      $display("** selective_repeat_sender_window_core: FAILED **");
    end
    $finish;
  end

  // Ends a run in which a handshake or a result never arrives.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("** selective_repeat_sender_window_core: FAILED **");
    $finish;
  end

endmodule
